// ----- rtl/core/srmm_pkg.sv -----
// Shared constants, types and state encoding for the step response metric monitor.
package srmm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 20;

  localparam int BAND_W  = 16;
  localparam int WGT_W   = 8;
  localparam int DEN_W   = WGT_W + 2;
  localparam int OVS_W   = SAMPLE_BITS + 1;
  localparam int SCORE_W = COUNT_BITS + 1;
  localparam int ERR_W   = SAMPLE_BITS + 1;
  localparam int MA_W    = (COUNT_BITS + 1 > SAMPLE_BITS + 2) ? COUNT_BITS + 1 : SAMPLE_BITS + 2;
  localparam int MB_W    = BAND_W;
  localparam int PROD_W  = MA_W + MB_W + 1;
  localparam int NUM_W   = ((COUNT_BITS > OVS_W) ? COUNT_BITS : OVS_W) + WGT_W + 3;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = BAND_W;

  localparam logic [CFG_IDX_W-1:0] REG_RISE_BAND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_BAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W_RISE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_OVS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_SETTLE    = 3'd4;

  localparam logic [BAND_W-1:0] RISE_BAND_RST   = 16'd6554;
  localparam logic [BAND_W-1:0] SETTLE_BAND_RST = 16'd1311;
  localparam logic [WGT_W-1:0]  WGT_RST         = 8'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BAND_R,
    S_BAND_S,
    S_UPD,
    S_MUL_R,
    S_MUL_O,
    S_MUL_S,
    S_ACC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/srmm_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module srmm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  srmm_pkg::div_ctrl_t             ctrl,
  input  logic [srmm_pkg::NUM_W-1:0]      dividend,
  input  logic [srmm_pkg::DEN_W-1:0]      divisor,
  output srmm_pkg::div_stat_t             stat,
  output logic [srmm_pkg::NUM_W-1:0]      quotient
);

  logic [srmm_pkg::NUM_W-1:0]  quo;
  logic [srmm_pkg::DEN_W-1:0]  rem;
  logic [srmm_pkg::DEN_W-1:0]  den;
  logic [srmm_pkg::DCNT_W-1:0] cnt;
  logic                        busy;
  logic                        done;

  logic [srmm_pkg::DEN_W:0]    rem_sh;
  logic [srmm_pkg::DEN_W:0]    diff;
  logic                        qbit;
  logic [srmm_pkg::DEN_W-1:0]  rem_next;

  always_comb begin
    rem_sh   = {rem, quo[srmm_pkg::NUM_W-1]};
    diff     = rem_sh - {1'b0, den};
    qbit     = ~diff[srmm_pkg::DEN_W];
    rem_next = qbit ? diff[srmm_pkg::DEN_W-1:0] : rem_sh[srmm_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= srmm_pkg::DCNT_W'(srmm_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == srmm_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[srmm_pkg::NUM_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ----- rtl/core/step_response_metric_monitor.sv -----
// Step response metric monitor: top level with sequencer, shared multiplier and divider.
//
// Usage:
//   sample channel: measured/setpoint with sample_valid, accepted when sample_stall is low.
//   result channel: rise_samples, overshoot, settle_samples, score, armed with
//     result_valid, taken when result_stall is low.
//   cfg channel: cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//     Index 0 rise band, 1 settle band, 2..4 weights of rise, overshoot, settle.
//     Write only while the block is idle.
// Path from accept to result_valid:
//   a re-arm or setpoint change item goes from idle straight to S_DONE,
//   a sample outside the settling band, or with all weights zero, passes the two band products and the update,
//   and when the score is recomputed the two band products, three weighted
//   products on the shared multiplier and one accumulate are followed by the
//   one-bit-per-cycle divider (31 steps) for the weighted average.
// One item at a time; sample_stall holds until its result loads, so no new item is accepted before then.
// The result sits in an output register, so a new item is accepted while it
// waits; a finished second item holds until the first is taken.
// Reset clears all metric state and loads the default register values;
// the first item after reset re-arms the monitor.
module step_response_metric_monitor (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [srmm_pkg::SAMPLE_BITS-1:0] measured,
  input  logic signed [srmm_pkg::SAMPLE_BITS-1:0] setpoint,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [srmm_pkg::COUNT_BITS-1:0]        rise_samples,
  output logic signed [srmm_pkg::OVS_W-1:0]      overshoot,
  output logic [srmm_pkg::COUNT_BITS-1:0]        settle_samples,
  output logic signed [srmm_pkg::SCORE_W-1:0]    score,
  output logic                                   armed,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [srmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [srmm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam logic [srmm_pkg::COUNT_BITS-1:0] CMAX = '1;

  srmm_pkg::state_t state, state_next;

  logic [srmm_pkg::BAND_W-1:0] rise_band, settle_band;
  logic [srmm_pkg::WGT_W-1:0]  w_rise, w_ovs, w_settle;

  logic                                   armed_flag;
  logic signed [srmm_pkg::SAMPLE_BITS-1:0] start_value;
  logic signed [srmm_pkg::SAMPLE_BITS-1:0] prev_setpoint;
  logic                                   rise_done;
  logic [srmm_pkg::COUNT_BITS-1:0]        rise_count;
  logic signed [srmm_pkg::SAMPLE_BITS-1:0] peak_value;
  logic [srmm_pkg::COUNT_BITS-1:0]        settle_count;
  logic signed [srmm_pkg::SCORE_W-1:0]    score_reg;

  logic signed [srmm_pkg::SAMPLE_BITS-1:0] m_reg, sp_reg;
  logic [srmm_pkg::ERR_W-1:0]             err, span;
  logic                                   out_rise;
  logic signed [srmm_pkg::PROD_W-1:0]     prod;
  logic signed [srmm_pkg::NUM_W-1:0]      acc;
  logic                                   num_neg;

  logic                                   accept;
  logic signed [srmm_pkg::ERR_W-1:0]      err_d, span_d;
  logic [srmm_pkg::ERR_W-1:0]             err_mag, span_mag;
  logic signed [srmm_pkg::OVS_W-1:0]      ovs;
  logic [srmm_pkg::PROD_W-1:0]            err_sh;
  logic                                   beyond;
  logic [srmm_pkg::DEN_W-1:0]             wsum;
  logic signed [srmm_pkg::NUM_W-1:0]      acc_sum;
  logic [srmm_pkg::NUM_W-1:0]             num_mag;
  logic signed [srmm_pkg::MA_W-1:0]       mul_a;
  logic [srmm_pkg::MB_W-1:0]              mul_b;
  logic                                   res_load;

  srmm_pkg::div_ctrl_t                    div_ctrl;
  srmm_pkg::div_stat_t                    div_stat;
  logic [srmm_pkg::NUM_W-1:0]             quotient;

  assign accept    = sample_valid & ~sample_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    err_d    = {setpoint[srmm_pkg::SAMPLE_BITS-1], setpoint}
             - {measured[srmm_pkg::SAMPLE_BITS-1], measured};
    span_d   = {setpoint[srmm_pkg::SAMPLE_BITS-1], setpoint}
             - {start_value[srmm_pkg::SAMPLE_BITS-1], start_value};
    err_mag  = err_d[srmm_pkg::ERR_W-1] ? -err_d : err_d;
    span_mag = span_d[srmm_pkg::ERR_W-1] ? -span_d : span_d;
    ovs      = {peak_value[srmm_pkg::SAMPLE_BITS-1], peak_value}
             - {sp_reg[srmm_pkg::SAMPLE_BITS-1], sp_reg};
    err_sh   = {{(srmm_pkg::PROD_W - srmm_pkg::ERR_W - 16){1'b0}}, err, 16'd0};
    beyond   = err_sh > $unsigned(prod);
    wsum     = srmm_pkg::DEN_W'(w_rise) + srmm_pkg::DEN_W'(w_ovs) + srmm_pkg::DEN_W'(w_settle);
    acc_sum  = acc + prod[srmm_pkg::NUM_W-1:0];
    num_mag  = acc[srmm_pkg::NUM_W-1] ? -acc : acc;
    res_load = (state == srmm_pkg::S_DONE) && (!result_valid || !result_stall);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srmm_pkg::S_IDLE: begin
        if (accept) begin
          if (!armed_flag || setpoint != prev_setpoint) state_next = srmm_pkg::S_DONE;
          else state_next = srmm_pkg::S_BAND_R;
        end
      end
      srmm_pkg::S_BAND_R: state_next = srmm_pkg::S_BAND_S;
      srmm_pkg::S_BAND_S: state_next = srmm_pkg::S_UPD;
      srmm_pkg::S_UPD: begin
        if (beyond || wsum == '0) state_next = srmm_pkg::S_DONE;
        else state_next = srmm_pkg::S_MUL_R;
      end
      srmm_pkg::S_MUL_R: state_next = srmm_pkg::S_MUL_O;
      srmm_pkg::S_MUL_O: state_next = srmm_pkg::S_MUL_S;
      srmm_pkg::S_MUL_S: state_next = srmm_pkg::S_ACC;
      srmm_pkg::S_ACC: state_next = srmm_pkg::S_DIV_GO;
      srmm_pkg::S_DIV_GO: state_next = srmm_pkg::S_DIV_WAIT;
      srmm_pkg::S_DIV_WAIT: begin
        if (div_stat.done) state_next = srmm_pkg::S_DONE;
      end
      srmm_pkg::S_DONE: begin
        if (res_load) state_next = srmm_pkg::S_IDLE;
      end
      default: state_next = srmm_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    sample_stall   = (state != srmm_pkg::S_IDLE);
    div_ctrl.start = (state == srmm_pkg::S_DIV_GO);
    mul_a          = '0;
    mul_b          = '0;
    case (state)
      srmm_pkg::S_BAND_R: begin
        mul_a = $signed({{(srmm_pkg::MA_W - srmm_pkg::ERR_W){1'b0}}, span});
        mul_b = rise_band;
      end
      srmm_pkg::S_BAND_S: begin
        mul_a = $signed({{(srmm_pkg::MA_W - srmm_pkg::ERR_W){1'b0}}, span});
        mul_b = settle_band;
      end
      srmm_pkg::S_MUL_R: begin
        mul_a = $signed({{(srmm_pkg::MA_W - srmm_pkg::COUNT_BITS){1'b0}}, rise_count});
        mul_b = srmm_pkg::MB_W'(w_rise);
      end
      srmm_pkg::S_MUL_O: begin
        mul_a = {{(srmm_pkg::MA_W - srmm_pkg::OVS_W){ovs[srmm_pkg::OVS_W-1]}}, ovs};
        mul_b = srmm_pkg::MB_W'(w_ovs);
      end
      srmm_pkg::S_MUL_S: begin
        mul_a = $signed({{(srmm_pkg::MA_W - srmm_pkg::COUNT_BITS){1'b0}}, settle_count});
        mul_b = srmm_pkg::MB_W'(w_settle);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  srmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (num_mag),
    .divisor  (wsum),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srmm_pkg::S_IDLE;
      rise_band     <= srmm_pkg::RISE_BAND_RST;
      settle_band   <= srmm_pkg::SETTLE_BAND_RST;
      w_rise        <= srmm_pkg::WGT_RST;
      w_ovs         <= srmm_pkg::WGT_RST;
      w_settle      <= srmm_pkg::WGT_RST;
      armed_flag    <= 1'b0;
      start_value   <= '0;
      prev_setpoint <= '0;
      rise_done     <= 1'b0;
      rise_count    <= '0;
      peak_value    <= '0;
      settle_count  <= '0;
      score_reg     <= '0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srmm_pkg::REG_RISE_BAND:   rise_band   <= cfg_data;
          srmm_pkg::REG_SETTLE_BAND: settle_band <= cfg_data;
          srmm_pkg::REG_W_RISE:      w_rise      <= cfg_data[srmm_pkg::WGT_W-1:0];
          srmm_pkg::REG_W_OVS:       w_ovs       <= cfg_data[srmm_pkg::WGT_W-1:0];
          srmm_pkg::REG_W_SETTLE:    w_settle    <= cfg_data[srmm_pkg::WGT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (!armed_flag) begin
          armed_flag    <= 1'b1;
          start_value   <= measured;
          prev_setpoint <= setpoint;
          rise_done     <= 1'b0;
          rise_count    <= srmm_pkg::COUNT_BITS'(1);
          peak_value    <= measured;
          settle_count  <= '0;
          score_reg     <= '0;
        end else if (setpoint != prev_setpoint) begin
          armed_flag <= 1'b0;
        end
      end
      if (state == srmm_pkg::S_UPD) begin
        if (!rise_done && out_rise) begin
          if (rise_count != CMAX) rise_count <= rise_count + 1'b1;
        end else begin
          rise_done <= 1'b1;
        end
        if (sp_reg >= 0) begin
          if (m_reg > peak_value) peak_value <= m_reg;
        end else begin
          if (m_reg < peak_value) peak_value <= m_reg;
        end
        if (beyond) begin
          if (settle_count != CMAX) settle_count <= settle_count + 1'b1;
        end else if (wsum == '0) begin
          score_reg <= '0;
        end
      end
      if (state == srmm_pkg::S_DIV_WAIT && div_stat.done) begin
        score_reg <= num_neg ? $signed(quotient[srmm_pkg::SCORE_W-1:0])
                             : -$signed(quotient[srmm_pkg::SCORE_W-1:0]);
      end
      if (res_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    prod <= mul_a * $signed({1'b0, mul_b});
    if (accept) begin
      m_reg  <= measured;
      sp_reg <= setpoint;
      err    <= err_mag;
      span   <= span_mag;
    end
    if (state == srmm_pkg::S_BAND_S) out_rise <= beyond;
    if (state == srmm_pkg::S_MUL_O) acc <= prod[srmm_pkg::NUM_W-1:0];
    if (state == srmm_pkg::S_MUL_S || state == srmm_pkg::S_ACC) acc <= acc_sum;
    if (state == srmm_pkg::S_DIV_GO) num_neg <= acc[srmm_pkg::NUM_W-1];
    if (res_load) begin
      rise_samples   <= rise_count;
      overshoot      <= ovs;
      settle_samples <= settle_count;
      score          <= score_reg;
      armed          <= armed_flag;
    end
  end

endmodule

// ----- rtl/core/srmm_chk.sv -----
// Port-level checker for the step response metric monitor, with its bind.
module srmm_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   sample_valid,
  input logic                                   sample_stall,
  input logic                                   result_valid,
  input logic                                   result_stall,
  input logic [srmm_pkg::COUNT_BITS-1:0]        rise_samples,
  input logic signed [srmm_pkg::SCORE_W-1:0]    score
);

  logic [1:0] pend;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = sample_valid & ~sample_stall;
  assign out_acc = result_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> sample_stall)
    else $error("item accepted but block not busy next cycle");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pend != 2'd0)
    else $error("result shown with no item pending");

  a_item_limit: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> pend < 2'd2)
    else $error("item accepted with two results outstanding");

  a_rise_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> rise_samples != '0)
    else $error("rise count of zero reported");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(score))
    else $error("stalled result changed");

endmodule

bind step_response_metric_monitor srmm_chk u_srmm_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .rise_samples (rise_samples),
  .score        (score)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the step response monitor: directed and random streams against a predictor.
module tb_top;
  import srmm_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] meas;
    logic signed [SAMPLE_BITS-1:0] sp;
  } sample_t;

  typedef struct {
    logic [COUNT_BITS-1:0]     rise;
    logic signed [OVS_W-1:0]   ovs;
    logic [COUNT_BITS-1:0]     settle;
    logic signed [SCORE_W-1:0] score;
    logic                      armed;
  } metrics_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [SAMPLE_BITS-1:0] measured = '0;
  logic signed [SAMPLE_BITS-1:0] setpoint = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [COUNT_BITS-1:0] rise_samples;
  logic signed [OVS_W-1:0] overshoot;
  logic [COUNT_BITS-1:0] settle_samples;
  logic signed [SCORE_W-1:0] score;
  logic armed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  step_response_metric_monitor dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .measured       (measured),
    .setpoint       (setpoint),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .rise_samples   (rise_samples),
    .overshoot      (overshoot),
    .settle_samples (settle_samples),
    .score          (score),
    .armed          (armed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register mirror
  logic [BAND_W-1:0] band_rise   = RISE_BAND_RST;
  logic [BAND_W-1:0] band_settle = SETTLE_BAND_RST;
  logic [WGT_W-1:0]  wgt_rise    = WGT_RST;
  logic [WGT_W-1:0]  wgt_ovs     = WGT_RST;
  logic [WGT_W-1:0]  wgt_settle  = WGT_RST;

  // step tracking state
  logic                          trk_armed = 1'b0;
  logic signed [SAMPLE_BITS-1:0] trk_start = '0;
  logic signed [SAMPLE_BITS-1:0] trk_prev_sp = '0;
  logic                          trk_rise_done = 1'b0;
  logic [COUNT_BITS-1:0]         trk_rise = '0;
  logic signed [SAMPLE_BITS-1:0] trk_peak = '0;
  logic [COUNT_BITS-1:0]         trk_settle = '0;
  longint                        trk_score = 0;

  sample_t  sample_backlog[$];
  metrics_t metrics_due[$];
  int samples_offered = 0;
  int samples_taken = 0;
  int queued_items = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_odds = 6;
  int gap_left = 0;
  int stall_left = 0;
  logic signed [SAMPLE_BITS-1:0] last_sp = '0;
  sample_t cur_sample;

  function automatic void track_step(input logic signed [SAMPLE_BITS-1:0] m,
                                     input logic signed [SAMPLE_BITS-1:0] sp);
    longint err, span, num, wsum;
    metrics_t r;
    if (!trk_armed) begin
      trk_armed = 1'b1;
      trk_start = m;
      trk_prev_sp = sp;
      trk_rise_done = 1'b0;
      trk_rise = COUNT_BITS'(1);
      trk_peak = m;
      trk_settle = '0;
      trk_score = 0;
    end else if (sp != trk_prev_sp) begin
      trk_armed = 1'b0;
    end else begin
      err = longint'(sp) - longint'(m);
      if (err < 0) err = -err;
      err = err * 65536;
      span = longint'(sp) - longint'(trk_start);
      if (span < 0) span = -span;
      if (!trk_rise_done && err > span * longint'(band_rise)) begin
        if (trk_rise != '1) trk_rise++;
      end else begin
        trk_rise_done = 1'b1;
      end
      if (sp >= 0) begin
        if (m > trk_peak) trk_peak = m;
      end else if (m < trk_peak) begin
        trk_peak = m;
      end
      if (err > span * longint'(band_settle)) begin
        if (trk_settle != '1) trk_settle++;
      end else begin
        wsum = longint'(wgt_rise) + longint'(wgt_ovs) + longint'(wgt_settle);
        if (wsum == 0) begin
          trk_score = 0;
        end else begin
          num = longint'(trk_rise) * longint'(wgt_rise)
              + (longint'(trk_peak) - longint'(sp)) * longint'(wgt_ovs)
              + longint'(trk_settle) * longint'(wgt_settle);
          trk_score = -(num / wsum);
        end
      end
      trk_prev_sp = sp;
    end
    r.rise   = trk_rise;
    r.ovs    = OVS_W'(longint'(trk_peak) - longint'(sp));
    r.settle = trk_settle;
    r.score  = SCORE_W'(trk_score);
    r.armed  = trk_armed;
    metrics_due.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (mismatches < 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endtask

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!(sample_valid && samples_taken != samples_offered)) begin
      if (gap_left != 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (sample_backlog.size() != 0) begin
        cur_sample = sample_backlog.pop_front();
        sample_valid <= 1'b1;
        measured <= cur_sample.meas;
        setpoint <= cur_sample.sp;
        samples_offered++;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) gap_left = $urandom_range(1, 17);
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!rst && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(0, 16);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    metrics_t want;
    logic progress;
    progress = 1'b0;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        progress = 1'b1;
        if (metrics_due.size() == 0) begin
          flag_mismatch("unexpected result, rise_samples", 0, 32'(rise_samples));
        end else begin
          want = metrics_due.pop_front();
          if (rise_samples !== want.rise)
            flag_mismatch("rise_samples", 32'(want.rise), 32'(rise_samples));
          if (overshoot !== want.ovs)
            flag_mismatch("overshoot", 32'(want.ovs), 32'(overshoot));
          if (settle_samples !== want.settle)
            flag_mismatch("settle_samples", 32'(want.settle), 32'(settle_samples));
          if (score !== want.score) flag_mismatch("score", 32'(want.score), 32'(score));
          if (armed !== want.armed) flag_mismatch("armed", 32'(want.armed), 32'(armed));
        end
      end
      if (sample_valid && !sample_stall) begin
        progress = 1'b1;
        samples_taken++;
        track_step(measured, setpoint);
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic add_sample(input logic signed [SAMPLE_BITS-1:0] m,
                            input logic signed [SAMPLE_BITS-1:0] sp);
    sample_t s;
    s.meas = m;
    s.sp = sp;
    sample_backlog.push_back(s);
    queued_items++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] any_sample();
    case ($urandom_range(0, 7))
      0: any_sample = S_MAX;
      1: any_sample = S_MIN;
      2: any_sample = SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
      default: any_sample = SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clip(input longint v);
    longint hi;
    hi = longint'(S_MAX);
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    clip = SAMPLE_BITS'(v);
  endfunction

  // one step: setpoint change, re-arm, then a decaying or ringing approach
  task automatic queue_step(input int len);
    logic signed [SAMPLE_BITS-1:0] sp, m0;
    longint e;
    int gain, jitter;
    sp = any_sample();
    m0 = $urandom_range(0, 1) ? last_sp : any_sample();
    gain = $urandom_range(0, 430) - 200;
    jitter = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : 0;
    add_sample(m0, sp);
    add_sample(m0, sp);
    e = longint'(m0) - longint'(sp);
    for (int k = 0; k < len; k++) begin
      e = e * gain / 256;
      if (jitter != 0) e += longint'($urandom_range(0, 2 * jitter)) - jitter;
      add_sample(clip(longint'(sp) + e), sp);
    end
    last_sp = sp;
  endtask

  task automatic queue_random(input int target);
    int first;
    first = queued_items;
    while (queued_items - first < target) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) add_sample(any_sample(), last_sp);
        1: repeat ($urandom_range(1, 4)) add_sample(any_sample(), any_sample());
        2: queue_step($urandom_range(30, 80));
        default: queue_step($urandom_range(2, 20));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (sample_backlog.size() != 0 || samples_taken != samples_offered ||
           metrics_due.size() != 0 || sample_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RISE_BAND:   band_rise = val;
      REG_SETTLE_BAND: band_settle = val;
      REG_W_RISE:      wgt_rise = val[WGT_W-1:0];
      REG_W_OVS:       wgt_ovs = val[WGT_W-1:0];
      REG_W_SETTLE:    wgt_settle = val[WGT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [BAND_W-1:0] rb, input logic [BAND_W-1:0] sb,
                           input logic [WGT_W-1:0] wr, input logic [WGT_W-1:0] wo,
                           input logic [WGT_W-1:0] ws);
    write_reg(REG_RISE_BAND, rb);
    write_reg(REG_SETTLE_BAND, sb);
    write_reg(REG_W_RISE, CFG_DATA_W'(wr));
    write_reg(REG_W_OVS, CFG_DATA_W'(wo));
    write_reg(REG_W_SETTLE, CFG_DATA_W'(ws));
  endtask

  task automatic write_random();
    write_all(BAND_W'($urandom), BAND_W'($urandom), WGT_W'($urandom_range(1, 255)),
              WGT_W'($urandom_range(1, 255)), WGT_W'($urandom_range(1, 255)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: span-zero steps, full-scale swings, setpoint changes both ways
    add_sample(SAMPLE_BITS'(0), SAMPLE_BITS'(0));
    add_sample(SAMPLE_BITS'(0), SAMPLE_BITS'(0));
    add_sample(S_MAX, SAMPLE_BITS'(0));
    add_sample(SAMPLE_BITS'(0), SAMPLE_BITS'(0));
    add_sample(SAMPLE_BITS'(0), S_MIN);
    add_sample(S_MAX, S_MIN);
    add_sample(S_MIN, S_MIN);
    add_sample(S_MIN, S_MIN);
    add_sample(S_MAX, S_MAX);
    add_sample(S_MIN, S_MAX);
    add_sample(S_MIN, S_MAX);
    add_sample(SAMPLE_BITS'(0), S_MAX);
    add_sample(SAMPLE_BITS'(29000), S_MAX);
    add_sample(S_MAX, S_MAX);
    add_sample(S_MAX, S_MAX);
    add_sample(SAMPLE_BITS'(-1), S_MAX);
    add_sample(S_MAX, SAMPLE_BITS'(32766));
    add_sample(SAMPLE_BITS'(-21846), SAMPLE_BITS'(21845));
    add_sample(SAMPLE_BITS'(21845), SAMPLE_BITS'(21845));
    add_sample(SAMPLE_BITS'(-5), SAMPLE_BITS'(-1));
    add_sample(SAMPLE_BITS'(-3), SAMPLE_BITS'(-1));
    add_sample(SAMPLE_BITS'(-2), SAMPLE_BITS'(-1));
    add_sample(SAMPLE_BITS'(-1), SAMPLE_BITS'(-1));
    last_sp = SAMPLE_BITS'(-1);
    wait_drained();

    write_all('1, '1, '1, '1, '1);
    for (int k = 1; k <= 3; k++) write_reg(REG_W_SETTLE + CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    idle_odds = 4;
    queue_random(120);
    wait_drained();

    write_all('0, '0, WGT_W'(1), WGT_W'(1), WGT_W'(1));
    idle_odds = 10;
    queue_random(60);
    wait_drained();
    queue_random(60);
    wait_drained();

    write_random();
    idle_odds = 3;
    queue_random(120);
    wait_drained();

    write_random();
    idle_odds = 0;
    queue_random(120);
    wait_drained();

    write_all('1, '0, WGT_W'($urandom_range(1, 255)), WGT_W'(1), WGT_W'(255));
    idle_odds = 5;
    queue_random(120);
    wait_drained();

    write_random();
    idle_odds = 0;
    queue_random(110);
    wait_drained();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && metrics_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/srmm_pkg.sv
rtl/core/srmm_div.sv
rtl/core/step_response_metric_monitor.sv
rtl/core/srmm_chk.sv
verif/tb_top.sv
